### rtl/xs128_pkg.sv
// ----------------------------------------------------------------------------
// xs128_pkg
// Types and constants shared by the xoshiro128** generator modules.
// ----------------------------------------------------------------------------
package xs128_pkg;

    localparam logic [31:0] BASE0 = 32'h343b2250;
    localparam logic [31:0] BASE1 = 32'h7336c098;
    localparam logic [31:0] BASE2 = 32'h03af11f5;
    localparam logic [31:0] BASE3 = 32'h92527961;

    localparam logic [19:0] MULT1 = 20'd55829;
    localparam logic [19:0] MULT2 = 20'd753499;
    localparam logic [19:0] MULT3 = 20'd859;

    localparam int          OUT_W    = 15;
    localparam logic [31:0] OUT_MASK = 32'h00007fff;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEED
    } back_state_t;

    typedef enum logic [1:0] {
        WSEL_NONE = 2'd0,
        WSEL_W1   = 2'd1,
        WSEL_W2   = 2'd2,
        WSEL_W3   = 2'd3
    } word_sel_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] seed;
    } cmd_item_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
        logic [63:0] dbl;
        dbl = {v, v} << amt;
        return dbl[63:32];
    endfunction

endpackage

### rtl/xs128_front.sv
// ----------------------------------------------------------------------------
// xs128_front
// Accepts input transactions, decodes the command and queues them.
// ----------------------------------------------------------------------------
module xs128_front
    import xs128_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_seed_value,
    output logic        q_valid,
    output cmd_item_t   q_item,
    input  logic        q_pop
);

    cmd_item_t           q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]     count_reg, count_next;
    logic                push;
    logic                pop;
    cmd_item_t           in_item;

    assign s_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        in_item.op   = s_cmd ? OP_SEED : OP_DRAW;
        in_item.seed = s_seed_value;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/xs128_back.sv
// ----------------------------------------------------------------------------
// xs128_back
// Generator state, draw scrambler, seed sequencer and output register.
// ----------------------------------------------------------------------------
module xs128_back
    import xs128_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_item_t         q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_random_value
);

    back_state_t       state_reg, state_next;
    logic [31:0]       w0_reg, w0_next;
    logic [31:0]       w1_reg, w1_next;
    logic [31:0]       w2_reg, w2_next;
    logic [31:0]       w3_reg, w3_next;
    logic [31:0]       seed_reg;
    word_sel_t         wsel_reg, wsel_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic              out_free;
    logic              do_draw;
    logic              do_seed;
    logic              do_mult;

    logic [31:0]       s1x5;
    logic [31:0]       rot;
    logic [31:0]       scrambled;
    logic [31:0]       t2, t3;

    logic [31:0]       mul_opnd;
    logic [19:0]       mul_const;
    logic [51:0]       mul_full;

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_item.op == OP_SEED) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                if (wsel_reg == WSEL_W3) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop   = 1'b0;
        do_draw = 1'b0;
        do_seed = 1'b0;
        do_mult = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_item.op == OP_SEED) begin
                    q_pop   = 1'b1;
                    do_seed = 1'b1;
                end else if (q_valid && out_free) begin
                    q_pop   = 1'b1;
                    do_draw = 1'b1;
                end
            end
            ST_SEED: begin
                do_mult = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // draw datapath
    always_comb begin
        s1x5      = w1_reg + {w1_reg[29:0], 2'b00};
        rot       = rotl32(s1x5, 5'd7);
        scrambled = rot + {rot[28:0], 3'b000};
        t2        = w2_reg ^ w0_reg;
        t3        = w3_reg ^ w1_reg;
    end

    // shared seed multiplier
    always_comb begin
        case (wsel_reg)
            WSEL_W1: begin
                mul_opnd  = rotl32(seed_reg ^ BASE1, 5'd5);
                mul_const = MULT1;
            end
            WSEL_W2: begin
                mul_opnd  = rotl32(seed_reg ^ BASE2, 5'd10);
                mul_const = MULT2;
            end
            WSEL_W3: begin
                mul_opnd  = rotl32(seed_reg ^ BASE3, 5'd17);
                mul_const = MULT3;
            end
            default: begin
                mul_opnd  = '0;
                mul_const = '0;
            end
        endcase
        mul_full = {20'b0, mul_opnd} * {32'b0, mul_const};
    end

    always_comb begin
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        wsel_next      = wsel_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (do_draw) begin
            w0_next        = w0_reg ^ t3;
            w1_next        = w1_reg ^ t2;
            w2_next        = t2 ^ {w1_reg[22:0], 9'b0};
            w3_next        = rotl32(t3, 5'd11);
            out_valid_next = 1'b1;
            out_data_next  = scrambled[OUT_W-1:0] & OUT_MASK[OUT_W-1:0];
        end
        if (do_seed) begin
            w0_next   = q_item.seed ^ BASE0;
            wsel_next = WSEL_W1;
        end
        if (do_mult) begin
            case (wsel_reg)
                WSEL_W1: begin
                    w1_next   = mul_full[31:0];
                    wsel_next = WSEL_W2;
                end
                WSEL_W2: begin
                    w2_next   = mul_full[31:0];
                    wsel_next = WSEL_W3;
                end
                WSEL_W3: begin
                    w3_next   = mul_full[31:0];
                    wsel_next = WSEL_NONE;
                end
                default: wsel_next = WSEL_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            w0_reg        <= BASE0;
            w1_reg        <= BASE1;
            w2_reg        <= BASE2;
            w3_reg        <= BASE3;
            wsel_reg      <= WSEL_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            w2_reg        <= w2_next;
            w3_reg        <= w3_next;
            wsel_reg      <= wsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (do_seed) begin
            seed_reg <= q_item.seed;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_random_value = out_data_reg;

endmodule

### rtl/xoshiro128ss_random_generator.sv
// ----------------------------------------------------------------------------
// xoshiro128ss_random_generator
// xoshiro128** generator with a 15-bit draw output and 32-bit reseeding.
// ----------------------------------------------------------------------------
// A draw transaction (cmd 0) returns one 15-bit value and advances the state;
// a seed transaction (cmd 1) reloads the state and returns nothing. Input
// transactions enter a two-entry queue, so the input side keeps taking them
// while a result waits on the output. Draws complete at one per cycle while
// the output is free and no seed runs. A seed occupies the back end to load
// word 0 and latch the seed, then each remaining word through a single shared
// 32x20 multiplier. Reset loads the four base constants; no clearing pass.
// ----------------------------------------------------------------------------
module xoshiro128ss_random_generator
    import xs128_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [31:0]       s_seed_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_random_value
);

    logic      q_valid;
    logic      q_pop;
    cmd_item_t q_item;

    xs128_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_seed_value (s_seed_value),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    xs128_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

endmodule
